@@ hw/rtl/dsq_pkg.sv @@
package dsq_pkg;

	// Queue geometry.
	localparam int DEPTH = 10;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Byte shown for an empty cell or when nothing was dequeued.
	localparam logic [7:0] EMPTY_MARK = 8'h2D;

	// Action codes. The spare code decodes as a dequeue.
	localparam logic [1:0] ACT_ENQ     = 2'd0;
	localparam logic [1:0] ACT_DEQ     = 2'd1;
	localparam logic [1:0] ACT_ENQ_OVW = 2'd2;
	localparam logic [1:0] ACT_SPARE   = 2'd3;

	// Target codes. The spare code decodes as a balanced choice.
	localparam logic [1:0] TGT_FIRST    = 2'd0;
	localparam logic [1:0] TGT_SECOND   = 2'd1;
	localparam logic [1:0] TGT_BALANCED = 2'd2;
	localparam logic [1:0] TGT_SPARE    = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_ENQ      = 3'd0;
	localparam logic [2:0] ST_DEQ      = 3'd1;
	localparam logic [2:0] ST_ENQ_DROP = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	// Command to one queue.
	typedef struct packed {
		logic shift;
		logic write;
	} dsq_qcmd_t;

	// Control of one cell.
	typedef struct packed {
		logic shift;
		logic load;
	} dsq_cell_ctl_t;

endpackage

@@ hw/rtl/dsq_cell.sv @@
module dsq_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dsq_pkg::dsq_cell_ctl_t ctl,
	input  logic [7:0]             next_byte,
	input  logic [7:0]             data,
	output logic [7:0]             byte_q
);

	// A load wins over a shift; on a shift alone the cell takes its neighbor's byte, else it holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= dsq_pkg::EMPTY_MARK;
		end else if (ctl.load) begin
			byte_q <= data;
		end else if (ctl.shift) begin
			byte_q <= next_byte;
		end
	end

endmodule

@@ hw/rtl/dsq_queue.sv @@
module dsq_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dsq_pkg::dsq_qcmd_t          cmd,
	input  logic [7:0]                  data,
	output logic [dsq_pkg::CNT_W-1:0]   fill_q,
	output logic [7:0]                  head,
	output logic [7:0]                  tail
);

	logic [7:0]                cell_q [dsq_pkg::DEPTH];
	logic [dsq_pkg::IDX_W-1:0] wr_idx;
	logic [dsq_pkg::IDX_W-1:0] tail_idx;

	// A write together with a shift lands in the last cell; otherwise in the first free one.
	assign wr_idx = cmd.shift ? dsq_pkg::IDX_W'(dsq_pkg::DEPTH - 1)
	                          : fill_q[dsq_pkg::IDX_W-1:0];

	// Row of cells; each hands its byte toward the head on a shift.
	for (genvar i = 0; i < dsq_pkg::DEPTH; i++) begin : g_cell
		dsq_pkg::dsq_cell_ctl_t ctl;
		logic [7:0]             next_byte;

		if (i == dsq_pkg::DEPTH - 1) begin : g_last
			assign next_byte = dsq_pkg::EMPTY_MARK;
		end else begin : g_mid
			assign next_byte = cell_q[i+1];
		end

		assign ctl.shift = cmd.shift;
		assign ctl.load  = cmd.write && (wr_idx == dsq_pkg::IDX_W'(i));

		dsq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.next_byte (next_byte),
			.data      (data),
			.byte_q    (cell_q[i])
		);
	end

	// Fill level: a shift with a write keeps it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.shift && !cmd.write) begin
			fill_q <= fill_q - dsq_pkg::CNT_W'(1);
		end else if (cmd.write && !cmd.shift) begin
			fill_q <= fill_q + dsq_pkg::CNT_W'(1);
		end
	end

	// Head and tail bytes, shown as the empty mark when nothing is held.
	assign tail_idx = dsq_pkg::IDX_W'(fill_q - dsq_pkg::CNT_W'(1));
	assign head     = (fill_q == '0) ? dsq_pkg::EMPTY_MARK : cell_q[0];
	assign tail     = (fill_q == '0) ? dsq_pkg::EMPTY_MARK : cell_q[tail_idx];

endmodule

@@ hw/rtl/dual_shifting_char_queue.sv @@
// Two shifting character queues of dsq_pkg::DEPTH bytes each.
// Input channel: in_valid / in_stall carry action, target and data. An
// operation is a transfer at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result per operation: the
// dequeued byte and flag, a status code, the queue acted on, both fill counts,
// the larger count and the head and tail bytes of both queues after the
// operation.
// Latency: the result is valid in the cycle after the input transfer.
// Throughput: one operation per cycle while in_stall is low. Every queue cell
// loads or shifts at once, so the fill counter update is the only per-item loop.
// While a result waits under out_stall, in_stall is high and the queues hold,
// so the count and head/tail fields stay stable with the result register.
// A result taken in the same cycle frees the block for the next transfer.
// Reset (arst_n low) empties both queues, sets every cell to '-' (0x2D) and
// drops out_valid. No clearing pass is needed afterwards.
module dual_shifting_char_queue (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic [1:0] target,
	input  logic [7:0] data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] popped,
	output logic       popped_valid,
	output logic [2:0] status,
	output logic       chosen_queue,
	output logic [3:0] first_count,
	output logic [3:0] second_count,
	output logic [3:0] longest_count,
	output logic [7:0] first_head,
	output logic [7:0] first_tail,
	output logic [7:0] second_head,
	output logic [7:0] second_tail
);

	logic                      take;
	logic                      is_deq;
	logic                      is_ovw;
	logic                      sel;
	logic [dsq_pkg::CNT_W-1:0] first_fill;
	logic [dsq_pkg::CNT_W-1:0] second_fill;
	logic [dsq_pkg::CNT_W-1:0] sel_fill;
	logic [dsq_pkg::CNT_W-1:0] longest;
	logic [7:0]                sel_head;
	logic                      sel_empty;
	logic                      sel_full;
	dsq_pkg::dsq_qcmd_t        cmd;
	dsq_pkg::dsq_qcmd_t        first_cmd;
	dsq_pkg::dsq_qcmd_t        second_cmd;
	logic [2:0]                status_d;
	logic                      out_valid_q;
	logic [7:0]                popped_q;
	logic                      popped_valid_q;
	logic [2:0]                status_q;
	logic                      chosen_q;

	// Handshake: hold new operations while a result is stalled.
	assign in_stall = out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;

	// Decode; action code 3 behaves as a dequeue.
	assign is_deq = action[0];
	assign is_ovw = (action == dsq_pkg::ACT_ENQ_OVW);

	// Queue choice; balanced and target code 3 pick by count, ties to the second queue.
	always_comb begin
		case (target)
			dsq_pkg::TGT_FIRST:  sel = 1'b0;
			dsq_pkg::TGT_SECOND: sel = 1'b1;
			default:             sel = is_deq ? !(first_fill > second_fill)
			                                  : !(first_fill < second_fill);
		endcase
	end

	assign sel_fill  = sel ? second_fill : first_fill;
	assign sel_head  = sel ? second_head : first_head;
	assign sel_empty = (sel_fill == '0);
	assign sel_full  = (sel_fill >= dsq_pkg::CNT_W'(dsq_pkg::DEPTH));

	// Command and status for the chosen queue.
	always_comb begin
		cmd = '0;
		if (is_deq) begin
			cmd.shift = !sel_empty;
			status_d  = sel_empty ? dsq_pkg::ST_EMPTY : dsq_pkg::ST_DEQ;
		end else if (sel_full) begin
			cmd.shift = is_ovw;
			cmd.write = is_ovw;
			status_d  = is_ovw ? dsq_pkg::ST_ENQ_DROP : dsq_pkg::ST_FULL;
		end else begin
			cmd.write = 1'b1;
			status_d  = dsq_pkg::ST_ENQ;
		end
	end

	assign first_cmd  = (take && !sel) ? cmd : '0;
	assign second_cmd = (take && sel)  ? cmd : '0;

	dsq_queue u_first (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (first_cmd),
		.data   (data),
		.fill_q (first_fill),
		.head   (first_head),
		.tail   (first_tail)
	);

	dsq_queue u_second (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (second_cmd),
		.data   (data),
		.fill_q (second_fill),
		.head   (second_head),
		.tail   (second_tail)
	);

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Per-operation result fields.
	always_ff @(posedge clk) begin
		if (take) begin
			popped_q       <= cmd.shift && is_deq ? sel_head : dsq_pkg::EMPTY_MARK;
			popped_valid_q <= cmd.shift && is_deq;
			status_q       <= status_d;
			chosen_q       <= sel;
		end
	end

	// Counts come straight from the queues, which hold while the result waits.
	assign longest = (first_fill > second_fill) ? first_fill : second_fill;

	assign out_valid     = out_valid_q;
	assign popped        = popped_q;
	assign popped_valid  = popped_valid_q;
	assign status        = status_q;
	assign chosen_queue  = chosen_q;
	assign first_count   = 4'(first_fill);
	assign second_count  = 4'(second_fill);
	assign longest_count = 4'(longest);

endmodule

@@ hw/rtl/dsq_checker.sv @@
module dsq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] popped,
	input logic       popped_valid,
	input logic [2:0] status,
	input logic [3:0] first_count,
	input logic [3:0] second_count,
	input logic [3:0] longest_count
);

	// Every input transfer yields a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("transfer without a result");

	// A valid popped byte only comes with a dequeue status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && popped_valid |-> status == dsq_pkg::ST_DEQ)
		else $error("popped byte without dequeue status");

	// An empty dequeue shows the empty mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dsq_pkg::ST_EMPTY |->
			popped == dsq_pkg::EMPTY_MARK && !popped_valid)
		else $error("empty dequeue shows a byte");

	// The longer count is one of the two counts and not below either.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> longest_count >= first_count && longest_count >= second_count
			&& (longest_count == first_count || longest_count == second_count))
		else $error("longest count wrong");

	// A stalled result keeps its status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result changed");

endmodule

bind dual_shifting_char_queue dsq_checker u_dsq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.popped        (popped),
	.popped_valid  (popped_valid),
	.status        (status),
	.first_count   (first_count),
	.second_count  (second_count),
	.longest_count (longest_count)
);
